// ===== hdl/tdw_pkg.sv =====
// Shared constants and types of the two-wire display serial writer.
package tdw_pkg;

  localparam int MaxBytes    = 7;
  localparam int ByteW       = 8;
  localparam int BitsPerByte = 8;
  localparam int BitIdxW     = $clog2(BitsPerByte);
  localparam int LenW        = $clog2(MaxBytes + 1);
  localparam int BufAw       = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  localparam logic OpTick = 1'b0;
  localparam logic OpPush = 1'b1;

  typedef struct packed {
    logic             en;
    logic [BufAw-1:0] addr;
    logic [ByteW-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic [LenW-1:0]    byte_idx;
    logic [BitIdxW-1:0] bit_idx;
  } buf_rd_t;

  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic dio_drive;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage

// ===== hdl/tdw_in_if.sv =====
// Input channel: tick and push items with valid/ready handshake.
interface tdw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [tdw_pkg::ByteW-1:0] byte_value;
  logic                     last_byte;
  logic                     dio_in;

  modport source (output valid, operation, byte_value, last_byte, dio_in, input ready);
  modport sink   (input valid, operation, byte_value, last_byte, dio_in, output ready);
endinterface

// ===== hdl/tdw_out_if.sv =====
// Output channel: one result item per input item with valid/ready handshake.
interface tdw_out_if;
  logic valid;
  logic ready;
  logic clk_out;
  logic dio_out;
  logic dio_drive;
  logic busy_res;
  logic frame_done;
  logic rejected;

  modport source (output valid, clk_out, dio_out, dio_drive, busy_res, frame_done, rejected,
                  input ready);
  modport sink   (input valid, clk_out, dio_out, dio_drive, busy_res, frame_done, rejected,
                  output ready);
endinterface

// ===== hdl/tdw_frame_buf.sv =====
// Frame byte buffer with a single write port and a registered byte read.
module tdw_frame_buf (
  input  logic             clk,
  input  tdw_pkg::buf_wr_t wr,
  input  tdw_pkg::buf_rd_t rd,
  output logic             bit_val
);
  import tdw_pkg::*;

  logic [ByteW-1:0] mem [MaxBytes];
  logic [ByteW-1:0] rd_byte;

  // Track the byte under byte_idx every cycle. The index settles at least one
  // item before its first data phase, so the held byte is always current there.
  // Index beyond the buffer reads as zero.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.byte_idx < LenW'(MaxBytes)) begin
      rd_byte <= mem[rd.byte_idx[BufAw-1:0]];
    end else begin
      rd_byte <= '0;
    end
  end

  assign bit_val = rd_byte[rd.bit_idx];

endmodule

// ===== hdl/tdw_sequencer.sv =====
// Phase sequencer: frame collection, bit phases, acknowledge wait and line levels.
module tdw_sequencer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     operation,
  input  logic [tdw_pkg::ByteW-1:0] byte_value,
  input  logic                     last_byte,
  input  logic                     dio_in,
  input  logic                     bit_val,
  output tdw_pkg::buf_wr_t         wr,
  output tdw_pkg::buf_rd_t         rd,
  output tdw_pkg::result_t         result
);
  import tdw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_INIT, PH_START, PH_CLK_FALL, PH_DATA_SET, PH_CLK_RISE, PH_DATA_HOLD,
    PH_ACK_SETUP, PH_ACK_RISE, PH_ACK_CHECK, PH_ACK_RESET, PH_STOP, PH_END
  } phase_t;

  phase_t             phase, phase_next;
  logic [BitIdxW-1:0] bit_index, bit_index_next;
  logic [LenW-1:0]    byte_index, byte_index_next;
  logic [LenW-1:0]    frame_length, frame_length_next;
  logic               line_clk, line_clk_next;
  logic               line_dio, line_dio_next;
  logic               line_drive, line_drive_next;
  logic               done, rej;
  logic [LenW-1:0]    byte_inc;

  assign rd.byte_idx = byte_index;
  assign rd.bit_idx  = bit_index;
  assign byte_inc    = byte_index + LenW'(1);

  always_comb begin
    phase_next        = phase;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    frame_length_next = frame_length;
    line_clk_next     = line_clk;
    line_dio_next     = line_dio;
    line_drive_next   = line_drive;
    done              = 1'b0;
    rej               = 1'b0;
    wr.en             = 1'b0;
    wr.addr           = frame_length[BufAw-1:0];
    wr.data           = byte_value;
    if (accept) begin
      if (operation == OpPush) begin
        if (phase != PH_IDLE) begin
          rej = 1'b1;
        end else if (frame_length >= LenW'(MaxBytes)) begin
          // Overflow: drop the partial frame.
          rej               = 1'b1;
          frame_length_next = '0;
        end else begin
          wr.en             = 1'b1;
          frame_length_next = frame_length + LenW'(1);
          if (last_byte) begin
            phase_next      = PH_INIT;
            bit_index_next  = '0;
            byte_index_next = '0;
          end
        end
      end else begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_INIT: begin
            line_clk_next   = 1'b1;
            line_dio_next   = 1'b1;
            line_drive_next = 1'b1;
            phase_next      = PH_START;
          end
          PH_START: begin
            line_clk_next   = 1'b1;
            line_dio_next   = 1'b0;
            line_drive_next = 1'b1;
            phase_next      = PH_CLK_FALL;
          end
          PH_CLK_FALL: begin
            line_clk_next = 1'b0;
            phase_next    = PH_DATA_SET;
          end
          PH_DATA_SET: begin
            line_clk_next   = 1'b0;
            line_dio_next   = bit_val;
            line_drive_next = 1'b1;
            phase_next      = PH_CLK_RISE;
          end
          PH_CLK_RISE: begin
            line_clk_next = 1'b1;
            phase_next    = PH_DATA_HOLD;
          end
          PH_DATA_HOLD: begin
            if (bit_index >= BitIdxW'(BitsPerByte - 1)) begin
              bit_index_next = '0;
              phase_next     = PH_ACK_SETUP;
            end else begin
              bit_index_next = bit_index + BitIdxW'(1);
              phase_next     = PH_CLK_FALL;
            end
          end
          PH_ACK_SETUP: begin
            line_clk_next   = 1'b0;
            line_dio_next   = 1'b1;
            line_drive_next = 1'b0;
            phase_next      = PH_ACK_RISE;
          end
          PH_ACK_RISE: begin
            line_clk_next = 1'b1;
            phase_next    = PH_ACK_CHECK;
          end
          PH_ACK_CHECK: begin
            // Hold until the partner pulls data low.
            if (!dio_in) begin
              phase_next = PH_ACK_RESET;
            end
          end
          PH_ACK_RESET: begin
            line_clk_next   = 1'b0;
            line_dio_next   = 1'b0;
            line_drive_next = 1'b1;
            byte_index_next = byte_inc;
            phase_next      = (byte_inc < frame_length) ? PH_CLK_FALL : PH_STOP;
          end
          PH_STOP: begin
            line_clk_next   = 1'b1;
            line_dio_next   = 1'b0;
            line_drive_next = 1'b1;
            phase_next      = PH_END;
          end
          PH_END: begin
            line_clk_next     = 1'b1;
            line_dio_next     = 1'b1;
            line_drive_next   = 1'b1;
            frame_length_next = '0;
            byte_index_next   = '0;
            bit_index_next    = '0;
            phase_next        = PH_IDLE;
            done              = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.clk_out    = line_clk_next;
    result.dio_out    = line_drive_next ? line_dio_next : 1'b1;
    result.dio_drive  = line_drive_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.frame_done = done;
    result.rejected   = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_index    <= '0;
      byte_index   <= '0;
      frame_length <= '0;
      line_clk     <= 1'b1;
      line_dio     <= 1'b1;
      line_drive   <= 1'b1;
    end else begin
      phase        <= phase_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      frame_length <= frame_length_next;
      line_clk     <= line_clk_next;
      line_dio     <= line_dio_next;
      line_drive   <= line_drive_next;
    end
  end

endmodule

// ===== hdl/tdw_out_reg.sv =====
// Result register: holds one result item and derives input ready.
module tdw_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  tdw_pkg::result_t result,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output tdw_pkg::result_t out_data
);
  import tdw_pkg::*;

  // Take a new item when empty or when the held one leaves this cycle.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ===== hdl/two_wire_display_serial_writer.sv =====
// Top level of the two-wire display serial writer.
// Usage:
//   cmd carries items: a push (operation = 1) stores byte_value in the frame
//   buffer, and a push with last_byte set starts the frame; a tick
//   (operation = 0) advances a running line sequence by one phase, or holds
//   it while awaiting the acknowledge, read from dio_in, the sampled data line.
//   res returns one result item per cmd item: line levels after the item,
//   busy_res, a frame_done pulse at the end of the stop and a rejected flag
//   for pushes taken while busy or into a full buffer (which drops the
//   partial frame).
// Latency and throughput:
//   each item is worked in the cycle it is accepted; its result is valid on
//   res in the next cycle. One item per cycle is sustained while res is ready,
//   set by the single result register after the phase logic.
// Stalls and reset:
//   while res is stalled with a result held, cmd ready stays low; a result
//   leaving lets a new item enter in the same cycle. Reset returns the
//   sequencer to idle with clock and data high and driven, and empties the
//   result register; the frame buffer holds its bytes and is overwritten.
module two_wire_display_serial_writer (
  input logic       clk,
  input logic       rst,
  tdw_in_if.sink    cmd,
  tdw_out_if.source res
);
  import tdw_pkg::*;

  logic    accept;
  logic    bit_val;
  buf_wr_t wr;
  buf_rd_t rd;
  result_t result;
  result_t res_data;

  assign accept = cmd.valid && cmd.ready;

  tdw_frame_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .bit_val (bit_val)
  );

  tdw_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (cmd.operation),
    .byte_value (cmd.byte_value),
    .last_byte  (cmd.last_byte),
    .dio_in     (cmd.dio_in),
    .bit_val    (bit_val),
    .wr         (wr),
    .rd         (rd),
    .result     (result)
  );

  tdw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .result    (result),
    .out_ready (res.ready),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_data  (res_data)
  );

  // Unpack the held result onto the channel.
  assign res.clk_out    = res_data.clk_out;
  assign res.dio_out    = res_data.dio_out;
  assign res.dio_drive  = res_data.dio_drive;
  assign res.busy_res   = res_data.busy_res;
  assign res.frame_done = res_data.frame_done;
  assign res.rejected   = res_data.rejected;

endmodule

// ===== sim/tb_two_wire_display_serial_writer.sv =====
// Self-checking testbench of the two-wire display serial writer: directed table, then random frames.
module tb_two_wire_display_serial_writer;
  import tdw_pkg::*;

  // Random items that advance or load the writer; idle ticks and pushes while busy do not count.
  localparam int RandItems     = 1950;
  // Long result hold-off, and the point in the random part where it is asked for.
  localparam int HoldOffCycles = 64;
  localparam int HoldOffAt     = 400;
  // Point in the random part where the sender drains every outstanding result.
  localparam int DrainPauseAt  = 1200;
  // One result register; idle cycles waited after the last owed result for any stray one.
  localparam int DrainCycles   = 4;
  localparam int MaxReports    = 100;
  localparam int RunLimit      = 4_000_000;

  // Sequencer phases, in the order the writer walks them.
  typedef enum logic [3:0] {
    PhIdle, PhInit, PhStart, PhClkFall, PhDataSet, PhClkRise, PhDataHold,
    PhAckSetup, PhAckRise, PhAckCheck, PhAckReset, PhStop, PhEnd
  } phase_e;

  // Patterns of the result receiver.
  typedef enum logic [1:0] {RdyAlways, RdyHalf, RdyMost, RdyThird} rdy_mode_e;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] bval;
    logic             last;
    logic             dio;
  } cmd_t;

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    result_t want;
  } dir_row_t;

  // Results that can be read off directly: idle lines, refusals, start of a frame.
  localparam result_t ResNone     = '0;
  localparam result_t ResIdle     = '{clk_out: 1'b1, dio_out: 1'b1, dio_drive: 1'b1,
                                      busy_res: 1'b0, frame_done: 1'b0, rejected: 1'b0};
  localparam result_t ResIdleRej  = '{clk_out: 1'b1, dio_out: 1'b1, dio_drive: 1'b1,
                                      busy_res: 1'b0, frame_done: 1'b0, rejected: 1'b1};
  localparam result_t ResBusyHigh = '{clk_out: 1'b1, dio_out: 1'b1, dio_drive: 1'b1,
                                      busy_res: 1'b1, frame_done: 1'b0, rejected: 1'b0};
  localparam result_t ResBusyRej  = '{clk_out: 1'b1, dio_out: 1'b1, dio_drive: 1'b1,
                                      busy_res: 1'b1, frame_done: 1'b0, rejected: 1'b1};
  localparam result_t ResStart    = '{clk_out: 1'b1, dio_out: 1'b0, dio_drive: 1'b1,
                                      busy_res: 1'b1, frame_done: 1'b0, rejected: 1'b0};

  // Directed part: idle ticks, a full buffer, an overflow push that drops the frame,
  // a one-byte frame of all ones, refused pushes while busy, and the first bit phases.
  // The frame started here runs on into the random part, which ticks it to its stop.
  localparam dir_row_t DirRows [24] = '{
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b1, ResIdle},     // tick while idle
    '{'{OpTick, 8'hFF, 1'b1, 1'b1}, 1'b1, ResIdle},
    '{'{OpPush, 8'h00, 1'b0, 1'b0}, 1'b1, ResIdle},     // fill the buffer
    '{'{OpPush, 8'hFF, 1'b0, 1'b1}, 1'b1, ResIdle},
    '{'{OpPush, 8'hA5, 1'b0, 1'b0}, 1'b1, ResIdle},
    '{'{OpPush, 8'h5A, 1'b0, 1'b1}, 1'b1, ResIdle},
    '{'{OpPush, 8'h01, 1'b0, 1'b0}, 1'b1, ResIdle},
    '{'{OpPush, 8'h80, 1'b0, 1'b1}, 1'b1, ResIdle},
    '{'{OpPush, 8'h3C, 1'b0, 1'b0}, 1'b1, ResIdle},
    '{'{OpPush, 8'hC3, 1'b1, 1'b1}, 1'b1, ResIdleRej},  // full: refused, last ignored
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b1, ResIdle},     // still idle after the drop
    '{'{OpPush, 8'hFF, 1'b1, 1'b0}, 1'b1, ResBusyHigh}, // new one-byte frame starts
    '{'{OpPush, 8'h00, 1'b1, 1'b1}, 1'b1, ResBusyRej},  // push while busy
    '{'{OpTick, 8'h00, 1'b0, 1'b1}, 1'b1, ResBusyHigh}, // init
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b1, ResStart},    // start condition
    '{'{OpTick, 8'h00, 1'b0, 1'b1}, 1'b0, ResNone},
    '{'{OpPush, 8'h12, 1'b0, 1'b0}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b1}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b1}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b1}, 1'b0, ResNone},
    '{'{OpTick, 8'h00, 1'b0, 1'b0}, 1'b0, ResNone}
  };

  logic clk;
  logic rst;

  tdw_in_if  cmd_if ();
  tdw_out_if res_if ();

  two_wire_display_serial_writer i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  // Own copy of the writer state.
  phase_e             ph;
  logic [BitIdxW-1:0] bit_i;
  logic [LenW-1:0]    byte_i;
  logic [LenW-1:0]    frm_len;
  logic [ByteW-1:0]   frm_mem [MaxBytes];
  logic               ln_clk;
  logic               ln_dio;
  logic               ln_drv;

  // Line levels and flags still owed by the writer, oldest first.
  result_t awaited_lines [$];
  // Items planned by the random generator but not yet offered.
  cmd_t    plan_q [$];

  // Typed-in expectation of the item on offer, if the table row has one.
  logic    cur_typed;
  result_t cur_want;

  int err_cnt;
  int items_in;
  int frames_seen;
  int rejects_seen;
  int ack_wait;
  int ack_hold;
  int ack_wait_max;
  int hold_cnt;
  int longest_hold;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one item to the writer state and return the lines and flags it leaves.
  function automatic result_t step_writer(input logic op, input logic [ByteW-1:0] bval,
                                          input logic last, input logic dio);
    result_t          r;
    logic             rej;
    logic             done;
    logic [ByteW-1:0] b;
    rej  = 1'b0;
    done = 1'b0;
    b    = '0;
    if (op == OpPush) begin
      if (ph != PhIdle) begin
        // busy: refuse, leave the frame on the wire alone
        rej = 1'b1;
      end else if (frm_len >= LenW'(MaxBytes)) begin
        // full: refuse and drop the partial frame, last_byte ignored
        rej     = 1'b1;
        frm_len = '0;
      end else begin
        frm_mem[frm_len] = bval;
        frm_len++;
        if (last) begin
          ph     = PhInit;
          bit_i  = '0;
          byte_i = '0;
        end
      end
    end else begin
      case (ph)
        PhInit: begin
          {ln_clk, ln_dio, ln_drv} = 3'b111;
          ph = PhStart;
        end
        PhStart: begin
          {ln_clk, ln_dio, ln_drv} = 3'b101;
          ph = PhClkFall;
        end
        PhClkFall: begin
          ln_clk = 1'b0;
          ph     = PhDataSet;
        end
        PhDataSet: begin
          b = (byte_i < LenW'(MaxBytes)) ? frm_mem[byte_i] : '0;
          {ln_clk, ln_dio, ln_drv} = {1'b0, b[bit_i], 1'b1};
          ph = PhClkRise;
        end
        PhClkRise: begin
          ln_clk = 1'b1;
          ph     = PhDataHold;
        end
        PhDataHold: begin
          if (bit_i == BitIdxW'(BitsPerByte - 1)) begin
            bit_i = '0;
            ph    = PhAckSetup;
          end else begin
            bit_i++;
            ph = PhClkFall;
          end
        end
        PhAckSetup: begin
          {ln_clk, ln_dio, ln_drv} = 3'b010;
          ph = PhAckRise;
        end
        PhAckRise: begin
          ln_clk = 1'b1;
          ph     = PhAckCheck;
        end
        PhAckCheck: begin
          // wait for the partner to pull data low, however long it takes
          if (!dio) ph = PhAckReset;
        end
        PhAckReset: begin
          {ln_clk, ln_dio, ln_drv} = 3'b001;
          byte_i++;
          ph = (byte_i < frm_len) ? PhClkFall : PhStop;
        end
        PhStop: begin
          {ln_clk, ln_dio, ln_drv} = 3'b101;
          ph = PhEnd;
        end
        PhEnd: begin
          {ln_clk, ln_dio, ln_drv} = 3'b111;
          frm_len = '0;
          byte_i  = '0;
          bit_i   = '0;
          ph      = PhIdle;
          done    = 1'b1;
        end
        default: ph = PhIdle;
      endcase
    end
    r.clk_out    = ln_clk;
    r.dio_out    = ln_drv ? ln_dio : 1'b1;   // released line reads as pulled up
    r.dio_drive  = ln_drv;
    r.busy_res   = (ph != PhIdle);
    r.frame_done = done;
    r.rejected   = rej;
    return r;
  endfunction

  // Build the next random item from the predicted state. Mostly well-formed frames
  // with random bytes and lengths, ticked through to the stop; some noise on top.
  function automatic cmd_t next_item(output bit counts);
    cmd_t c;
    int   pick;
    int   len;
    if (plan_q.size() == 0) begin
      if (ph == PhIdle) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // a frame: mostly short, now and then up to a full buffer
          pick = $urandom_range(0, 9);
          len  = (pick < 5) ? 1 : (pick < 8) ? $urandom_range(2, 3)
                                             : $urandom_range(4, MaxBytes);
          for (int k = 0; k < len; k++)
            plan_q.push_back('{OpPush, 8'($urandom_range(0, 255)), (k == len - 1),
                               1'($urandom_range(0, 1))});
        end else if (pick < 88) begin
          plan_q.push_back('{OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))});
        end else if (pick < 94) begin
          // overrun the buffer; the push that finds it full drops the frame whatever its last_byte
          for (int k = 0; k < MaxBytes; k++)
            plan_q.push_back('{OpPush, 8'($urandom_range(0, 255)), 1'b0,
                               1'($urandom_range(0, 1))});
          plan_q.push_back('{OpPush, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))});
        end else begin
          // stray bytes with no last, left for the next frame to append to
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            plan_q.push_back('{OpPush, 8'($urandom_range(0, 255)), 1'b0,
                               1'($urandom_range(0, 1))});
        end
      end else if ($urandom_range(0, 24) == 0) begin
        plan_q.push_back('{OpPush, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))});
      end else begin
        c = '{OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1))};
        if (ph == PhAckCheck) begin
          // now and then withhold the acknowledge for a long stretch
          if (ack_wait == 0) ack_hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : 0;
          if (ack_wait < ack_hold) c.dio = 1'b1;
          ack_wait++;
          if (ack_wait > ack_wait_max) ack_wait_max = ack_wait;
        end else begin
          ack_wait = 0;
        end
        plan_q.push_back(c);
      end
    end
    c      = plan_q.pop_front();
    counts = (c.op == OpPush) ? (ph == PhIdle) : (ph != PhIdle);
    return c;
  endfunction

  // Offer one item from this falling edge and hold it until the writer takes it.
  task automatic put_item(input cmd_t c, input logic typed, input result_t want);
    cmd_if.valid      <= 1'b1;
    cmd_if.operation  <= c.op;
    cmd_if.byte_value <= c.bval;
    cmd_if.last_byte  <= c.last;
    cmd_if.dio_in     <= c.dio;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t  %s mismatch: expected %0b, actual %0b", $time, name, want, got);
      else if (err_cnt == MaxReports + 1)
        $display("%0t  further mismatches not shown", $time);
    end
  endfunction

  // Sample both channels at the rising edge: check the leaving result first, then
  // predict the entering item. A result always belongs to an item of an earlier cycle.
  always @(posedge clk) begin : scoreboard
    result_t exp_r;
    result_t got_r;
    if (rst) begin
      ph      = PhIdle;
      bit_i   = '0;
      byte_i  = '0;
      frm_len = '0;
      {ln_clk, ln_dio, ln_drv} = 3'b111;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_r = '{res_if.clk_out, res_if.dio_out, res_if.dio_drive, res_if.busy_res,
                  res_if.frame_done, res_if.rejected};
        if (awaited_lines.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t  result with nothing expected: expected none, actual %b", $time, got_r);
        end else begin
          exp_r = awaited_lines.pop_front();
          check_field("clk_out",    exp_r.clk_out,    got_r.clk_out);
          check_field("dio_out",    exp_r.dio_out,    got_r.dio_out);
          check_field("dio_drive",  exp_r.dio_drive,  got_r.dio_drive);
          check_field("busy_res",   exp_r.busy_res,   got_r.busy_res);
          check_field("frame_done", exp_r.frame_done, got_r.frame_done);
          check_field("rejected",   exp_r.rejected,   got_r.rejected);
        end
        if (got_r.frame_done === 1'b1) frames_seen++;
        if (got_r.rejected === 1'b1)   rejects_seen++;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        // always advance the own state; a typed-in row overrides the prediction
        exp_r = step_writer(cmd_if.operation, cmd_if.byte_value, cmd_if.last_byte,
                            cmd_if.dio_in);
        awaited_lines.push_back(cur_typed ? cur_want : exp_r);
        items_in++;
      end
    end
  end

  // Result receiver: stretches of fixed patterns, and one long hold-off on request,
  // counted here, that fills the result register and stalls the input.
  initial begin : result_sink
    int        seg_len;
    rdy_mode_e mode;
    res_if.ready = 1'b0;
    forever begin
      seg_len = $urandom_range(4, 60);
      mode    = rdy_mode_e'($urandom_range(0, 3));
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        if (hold_off_req) begin
          res_if.ready <= 1'b0;
          hold_cnt++;
          if (hold_cnt >= HoldOffCycles) begin
            longest_hold = hold_cnt;
            hold_off_req = 1'b0;
          end
        end else begin
          case (mode)
            RdyAlways: res_if.ready <= 1'b1;
            RdyHalf:   res_if.ready <= 1'($urandom_range(0, 1));
            RdyMost:   res_if.ready <= ($urandom_range(0, 3) != 0);
            default:   res_if.ready <= (k % 3 == 0);
          endcase
        end
      end
    end
  end

  // Sender: reset, the directed table, then random items in bursts with gaps.
  initial begin : stimulus
    cmd_t c;
    bit   counts;
    int   counted;
    int   burst_left;
    int   gap;
    bit   hold_asked;
    bit   paused;
    rst                = 1'b1;
    cmd_if.valid       = 1'b0;
    cmd_if.operation   = OpTick;
    cmd_if.byte_value  = '0;
    cmd_if.last_byte   = 1'b0;
    cmd_if.dio_in      = 1'b1;
    cur_typed          = 1'b0;
    cur_want           = ResNone;
    hold_off_req       = 1'b0;
    counted            = 0;
    burst_left         = 0;
    hold_asked         = 1'b0;
    paused             = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table back to back.
    foreach (DirRows[i]) begin
      @(negedge clk);
      put_item(DirRows[i].c, DirRows[i].typed, DirRows[i].want);
    end

    while (counted < RandItems) begin
      if (burst_left == 0) begin
        // gap between bursts: mostly short, now and then long, sometimes none
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        repeat (gap) begin
          @(negedge clk);
          cmd_if.valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 40);
      end
      if (counted >= HoldOffAt && !hold_asked) begin
        // keep offering items while the receiver holds off
        hold_asked   = 1'b1;
        hold_off_req = 1'b1;
      end
      if (counted >= DrainPauseAt && !paused) begin
        // drop valid and wait until every owed result has left
        paused = 1'b1;
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (awaited_lines.size() != 0) @(posedge clk);
      end
      @(negedge clk);
      c = next_item(counts);
      put_item(c, 1'b0, ResNone);
      if (counts) counted++;
      burst_left--;
    end

    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (awaited_lines.size() != 0) @(posedge clk);
    // let anything stray show up after the last owed result
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d items: %0d frames sent to their stop, %0d pushes refused.",
             items_in, frames_seen, rejects_seen);
    $display("Longest acknowledge wait %0d ticks, longest result hold-off %0d cycles.",
             ack_wait_max, longest_hold);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #RunLimit;
    $display("Regression FAIL");
    $finish;
  end

endmodule
